[hdl/cmbu_pkg.sv]
// Shared constants, field widths and controller/datapath command and status types
// for the combination unrank unit. Depends on nothing.
package cmbu_pkg;

    localparam int ORD_W  = 50;
    localparam int K_W    = 4;
    localparam int KEY_W  = 9;
    localparam int POS_W  = 8;
    localparam int STAT_W = 2;

    localparam int MAX_KEY_BITS_DEF = 256;
    localparam int MAX_SET_BITS_DEF = 8;

    localparam logic [KEY_W-1:0] KEY_BITS_RST = 9'd256;

    localparam int APB_AW = 2;
    localparam int APB_DW = 32;
    localparam logic [APB_AW-1:0] ADDR_KEY_BITS = 2'd0;

    localparam logic [STAT_W-1:0] STAT_BIT  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NONE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_ERR  = 2'd2;

    typedef struct packed {
        logic fill;
        logic load;
        logic step;
        logic take_hit;
        logic emit_err;
        logic emit_none;
    } t_dp_cmd;

    typedef struct packed {
        logic fill_done;
        logic chk_err;
        logic chk_zero;
        logic hit;
        logic hit_last;
        logic out_free;
    } t_dp_stat;

endpackage

[hdl/cmbu_ifs.sv]
// Valid/ready channel interfaces for requests and results of the unrank unit.
// Depends on cmbu_pkg.
interface cmbu_req_if;
    import cmbu_pkg::*;

    logic             valid;
    logic             ready;
    logic [ORD_W-1:0] ordinal;
    logic [K_W-1:0]   mismatch_count;

    modport source (output valid, output ordinal, output mismatch_count, input ready);
    modport sink   (input valid, input ordinal, input mismatch_count, output ready);
endinterface

interface cmbu_res_if;
    import cmbu_pkg::*;

    logic              valid;
    logic              ready;
    logic [POS_W-1:0]  bit_position;
    logic [STAT_W-1:0] status;
    logic              last;

    modport source (output valid, output bit_position, output status, output last,
                    input ready);
    modport sink   (input valid, input bit_position, input status, input last,
                    output ready);
endinterface

[hdl/cmbu_cfg.sv]
// APB-style configuration register file holding the key width.
// Depends on cmbu_pkg.
module cmbu_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cmbu_pkg::APB_AW-1:0] paddr,
    input  logic [cmbu_pkg::APB_DW-1:0] pwdata,
    output logic [cmbu_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    output logic [cmbu_pkg::KEY_W-1:0]  o_key_bits
);
    import cmbu_pkg::*;

    logic [KEY_W-1:0] r_key_bits;
    logic             wr_key;

    assign wr_key = psel && penable && pwrite && (paddr == ADDR_KEY_BITS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_bits <= KEY_BITS_RST;
        end else if (wr_key) begin
            r_key_bits <= pwdata[KEY_W-1:0];
        end
    end

    assign prdata     = (paddr == ADDR_KEY_BITS) ? APB_DW'(r_key_bits) : '0;
    assign pready     = 1'b1;
    assign o_key_bits = r_key_bits;

endmodule

[hdl/cmbu_dp.sv]
// Datapath: binomial table memory with its fill logic, the ordinal and count
// registers, the compare/subtract step and the result register. Depends on cmbu_pkg.
module cmbu_dp #(
    parameter int MAX_KEY_BITS = cmbu_pkg::MAX_KEY_BITS_DEF,
    parameter int MAX_SET_BITS = cmbu_pkg::MAX_SET_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  cmbu_pkg::t_dp_cmd           i_cmd,
    output cmbu_pkg::t_dp_stat          o_stat,
    input  logic [cmbu_pkg::KEY_W-1:0]  i_key_bits,
    input  logic [cmbu_pkg::ORD_W-1:0]  i_ordinal,
    input  logic [cmbu_pkg::K_W-1:0]    i_mismatch_count,
    input  logic                        i_res_ready,
    output logic                        o_res_valid,
    output logic [cmbu_pkg::POS_W-1:0]  o_bit_position,
    output logic [cmbu_pkg::STAT_W-1:0] o_status,
    output logic                        o_last
);
    import cmbu_pkg::*;

    localparam int MEM_DEPTH = MAX_KEY_BITS + 1;
    localparam int AW        = $clog2(MEM_DEPTH);

    typedef logic [MAX_SET_BITS-1:0][ORD_W-1:0] t_row;

    t_row              r_mem [MEM_DEPTH];
    t_row              r_frow;
    t_row              n_frow;
    t_row              r_row;
    logic [AW-1:0]     r_fill_addr;
    logic [AW-1:0]     r_addr;
    logic [AW-1:0]     r_bit;
    logic [AW-1:0]     key_sat;
    logic [AW-1:0]     rd_addr;
    logic              rd_en;
    logic [ORD_W-1:0]  r_ord;
    logic [K_W-1:0]    r_k;
    logic [ORD_W-1:0]  csel;
    logic [ORD_W-1:0]  cmp_val;
    logic              hit;
    logic              out_wr;
    logic              out_free;
    logic              r_out_vld;
    logic [POS_W-1:0]  r_pos;
    logic [STAT_W-1:0] r_stat;
    logic              r_last;

    assign key_sat = (i_key_bits > KEY_W'(MAX_KEY_BITS)) ? AW'(MAX_KEY_BITS) : AW'(i_key_bits);

    always_comb begin
        n_frow[0] = r_frow[0] + ORD_W'(1);
        for (int j = 1; j < MAX_SET_BITS; j++) begin
            n_frow[j] = r_frow[j] + r_frow[j-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_addr <= '0;
            r_frow      <= '0;
        end else if (i_cmd.fill) begin
            r_fill_addr <= r_fill_addr + AW'(1);
            r_frow      <= n_frow;
        end
    end

    assign rd_en   = i_cmd.load || i_cmd.step;
    assign rd_addr = i_cmd.load ? key_sat : r_addr;

    always_ff @(posedge i_clk) begin
        if (i_cmd.fill) begin
            r_mem[r_fill_addr] <= r_frow;
        end
        if (rd_en) begin
            r_row <= r_mem[rd_addr];
        end
    end

    always_comb begin
        csel = '0;
        for (int j = 0; j < MAX_SET_BITS; j++) begin
            if (r_k == K_W'(j + 1)) begin
                csel = r_row[j];
            end
        end
    end

    assign cmp_val = (r_k == '0) ? ORD_W'(1) : csel;
    assign hit     = (r_ord >= csel);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ord  <= i_ordinal;
            r_k    <= i_mismatch_count;
            r_addr <= key_sat - AW'(1);
        end else begin
            if (i_cmd.step) begin
                r_bit  <= r_addr;
                r_addr <= r_addr - AW'(1);
            end
            if (i_cmd.take_hit) begin
                r_ord <= r_ord - csel;
                r_k   <= r_k - K_W'(1);
            end
        end
    end

    assign out_wr   = i_cmd.take_hit || i_cmd.emit_err || i_cmd.emit_none;
    assign out_free = !r_out_vld || i_res_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= out_wr || (r_out_vld && !i_res_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_wr) begin
            if (i_cmd.take_hit) begin
                r_pos  <= POS_W'(r_bit);
                r_stat <= STAT_BIT;
                r_last <= (r_k == K_W'(1));
            end else begin
                r_pos  <= '0;
                r_stat <= i_cmd.emit_none ? STAT_NONE : STAT_ERR;
                r_last <= 1'b1;
            end
        end
    end

    assign o_stat.fill_done = (r_fill_addr == AW'(MAX_KEY_BITS));
    assign o_stat.chk_err   = (r_k > K_W'(MAX_SET_BITS)) || (r_ord >= cmp_val);
    assign o_stat.chk_zero  = (r_k == '0);
    assign o_stat.hit       = hit;
    assign o_stat.hit_last  = (r_k == K_W'(1));
    assign o_stat.out_free  = out_free;

    assign o_res_valid    = r_out_vld;
    assign o_bit_position = r_pos;
    assign o_status       = r_stat;
    assign o_last         = r_last;

endmodule

[hdl/cmbu_ctrl.sv]
// Controller: sequences the table fill after reset, the range check and the
// downward bit scan of each request. Depends on cmbu_pkg.
module cmbu_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    output logic               o_req_ready,
    input  cmbu_pkg::t_dp_stat i_stat,
    output cmbu_pkg::t_dp_cmd  o_cmd
);
    import cmbu_pkg::*;

    typedef enum logic [1:0] {
        S_FILL,
        S_IDLE,
        S_CHK,
        S_SCAN
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_FILL: begin
                o_cmd.fill = 1'b1;
                if (i_stat.fill_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHK;
                end
            end
            S_CHK: begin
                if (i_stat.chk_err) begin
                    if (i_stat.out_free) begin
                        o_cmd.emit_err = 1'b1;
                        n_state        = S_IDLE;
                    end
                end else if (i_stat.chk_zero) begin
                    if (i_stat.out_free) begin
                        o_cmd.emit_none = 1'b1;
                        n_state         = S_IDLE;
                    end
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.hit) begin
                    if (i_stat.out_free) begin
                        o_cmd.take_hit = 1'b1;
                        if (i_stat.hit_last) begin
                            n_state = S_IDLE;
                        end else begin
                            o_cmd.step = 1'b1;
                        end
                    end
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_FILL;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);

endmodule

[hdl/combination_unrank_unit.sv]
// Top level of the combination unrank unit: configuration port, controller and
// datapath. Depends on cmbu_pkg, cmbu_ifs, cmbu_cfg, cmbu_ctrl and cmbu_dp.
//
// Each request on i_req carries an ordinal and a count k of bits to set. The
// unit turns the ordinal into a k-of-n bit pattern, n being the key_bits
// register, and sends one result on o_res per set bit, highest position first,
// with last marking the final one. A count of zero with a zero ordinal gives a
// single "no bits" result; an out-of-range ordinal or count gives a single
// error result. key_bits is written over the APB port at address 0; the user must
// write it only while idle, which the block itself does not enforce. After reset
// the unit fills its binomial table, one row a cycle, and accepts no request until
// that is done. A request is then loaded into the ordinal and count registers and
// checked in S_CHK; while the receiver does not stall, the scan visits one bit
// position per cycle from n-1 down to the lowest set bit. A request is accepted
// only when the previous one has finished, though its final result may still sit
// in the output register. When the receiver stalls, the scan holds at the next
// set bit until the output register frees up.
module combination_unrank_unit #(
    parameter int MAX_KEY_BITS = cmbu_pkg::MAX_KEY_BITS_DEF,
    parameter int MAX_SET_BITS = cmbu_pkg::MAX_SET_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    cmbu_req_if.sink                    i_req,
    cmbu_res_if.source                  o_res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cmbu_pkg::APB_AW-1:0] paddr,
    input  logic [cmbu_pkg::APB_DW-1:0] pwdata,
    output logic [cmbu_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);
    import cmbu_pkg::*;

    logic [KEY_W-1:0] key_bits;
    t_dp_cmd          cmd;
    t_dp_stat         stat;

    cmbu_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_key_bits (key_bits)
    );

    cmbu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    cmbu_dp #(
        .MAX_KEY_BITS (MAX_KEY_BITS),
        .MAX_SET_BITS (MAX_SET_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_key_bits       (key_bits),
        .i_ordinal        (i_req.ordinal),
        .i_mismatch_count (i_req.mismatch_count),
        .i_res_ready      (o_res.ready),
        .o_res_valid      (o_res.valid),
        .o_bit_position   (o_res.bit_position),
        .o_status         (o_res.status),
        .o_last           (o_res.last)
    );

endmodule
